/* hw/rtl/lpgf_pkg.sv */
// Shared constants and types for the luma preserving gamut fit block.
package lpgf_pkg;

	localparam int FRACTION_BITS = 16;
	localparam int WEIGHT_BITS   = 16;
	localparam int EPS_RAW       = (1 << FRACTION_BITS) / 1000000;
	localparam int EPS_LSB       = (EPS_RAW > 0) ? EPS_RAW : 1;
	localparam int LAM_ONE       = 1 << WEIGHT_BITS;

	localparam int CH_W    = 32;
	localparam int OUT_W   = 31;
	localparam int PROD_W  = 49;
	localparam int ACC_W   = 51;
	localparam int YRAW_W  = ACC_W - WEIGHT_BITS;
	localparam int OFS_W   = YRAW_W + 1;
	localparam int NUM_W   = OUT_W + WEIGHT_BITS;
	localparam int CMP_W   = OFS_W + WEIGHT_BITS;
	localparam int LAM_W   = WEIGHT_BITS + 1;
	localparam int MUL_W   = LAM_W + 1 + OFS_W;
	localparam int RND_W   = MUL_W - WEIGHT_BITS;
	localparam int SUM_W   = RND_W + 1;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam int DIV_STEPS = WEIGHT_BITS;
	localparam int B_STAGES  = DIV_STEPS + 4;

	localparam int ADDR_W = 4;

	typedef enum logic [1:0] {
		REG_PEAK  = 2'd0,
		REG_W_RED = 2'd1,
		REG_W_GRN = 2'd2,
		REG_W_BLU = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic                        fit;
		logic [2:0][CH_W-1:0]        x;
		logic [OUT_W-1:0]            y;
		logic [2:0][OFS_W-1:0]       c;
		logic [2:0][OUT_W-1:0]       bound;
		logic [2:0][OFS_W-1:0]       d;
		logic [2:0]                  act;
	} qent_t;

	typedef struct packed {
		logic                        fit;
		logic [2:0][CH_W-1:0]        x;
		logic [OUT_W-1:0]            y;
		logic [2:0][OFS_W-1:0]       c;
		logic [2:0][OFS_W-1:0]       d;
		logic [2:0][NUM_W-1:0]       rem;
		logic [2:0][LAM_W-1:0]       q;
		logic [2:0]                  done;
		logic [LAM_W-1:0]            lam;
		logic [2:0][MUL_W-1:0]       prod;
	} bstg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

/* hw/rtl/lpgf_front.sv */
// Front end: accepts pixels, classifies them and forms luma and offsets.
module lpgf_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [lpgf_pkg::OUT_W-1:0]       peak_level,
	input  logic [15:0]                      weight_red,
	input  logic [15:0]                      weight_green,
	input  logic [15:0]                      weight_blue,
	input  logic                             pix_valid,
	output logic                             pix_ready,
	input  logic signed [lpgf_pkg::CH_W-1:0] red_in,
	input  logic signed [lpgf_pkg::CH_W-1:0] green_in,
	input  logic signed [lpgf_pkg::CH_W-1:0] blue_in,
	input  lpgf_pkg::qstat_t                 qstat,
	output logic                             push,
	output lpgf_pkg::qent_t                  push_ent
);
	import lpgf_pkg::*;

	logic                       en;
	logic                       v_s1, v_s2, v_s3;
	logic signed [CH_W-1:0]     x_s1 [3];
	logic signed [CH_W-1:0]     x_s2 [3];
	logic signed [PROD_W-1:0]   p_s1 [3];
	logic                       fit_s1, fit_s2;
	logic signed [YRAW_W-1:0]   yraw_s2;
	logic signed [ACC_W-1:0]    acc;
	logic [15:0]                w [3];
	logic signed [CH_W-1:0]     xin [3];
	logic [2:0]                 oor;
	logic [OUT_W-1:0]           y_c;
	qent_t                      ent_c, ent_s3;

	assign en        = !v_s3 || !qstat.full;
	assign pix_ready = en;
	assign push      = v_s3 && !qstat.full;
	assign push_ent  = ent_s3;

	assign w[0] = weight_red;
	assign w[1] = weight_green;
	assign w[2] = weight_blue;
	assign xin[0] = red_in;
	assign xin[1] = green_in;
	assign xin[2] = blue_in;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			oor[i] = xin[i][CH_W-1] || (xin[i][OUT_W-1:0] > peak_level);
		end
		acc = ACC_W'(p_s1[0]) + ACC_W'(p_s1[1]) + ACC_W'(p_s1[2])
			+ ACC_W'(1 << (WEIGHT_BITS - 1));
	end

	always_comb begin
		if (yraw_s2 < 0) begin
			y_c = '0;
		end else if (yraw_s2 > $signed({{(YRAW_W-OUT_W){1'b0}}, peak_level})) begin
			y_c = peak_level;
		end else begin
			y_c = yraw_s2[OUT_W-1:0];
		end
		ent_c.fit = fit_s2;
		ent_c.y   = y_c;
		for (int i = 0; i < 3; i++) begin
			logic signed [OFS_W-1:0] ci;
			logic [OFS_W-1:0]        mag;
			ci = OFS_W'(x_s2[i]) - OFS_W'(yraw_s2);
			mag = ci[OFS_W-1] ? OFS_W'(-ci) : OFS_W'(ci);
			ent_c.x[i]     = x_s2[i];
			ent_c.c[i]     = ci;
			ent_c.bound[i] = ci[OFS_W-1] ? y_c : (peak_level - y_c);
			ent_c.d[i]     = (mag < OFS_W'(EPS_LSB)) ? OFS_W'(EPS_LSB) : mag;
			ent_c.act[i]   = (ci != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= pix_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				x_s1[i] <= xin[i];
				p_s1[i] <= $signed({1'b0, w[i]}) * xin[i];
				x_s2[i] <= x_s1[i];
			end
			fit_s1  <= |oor;
			fit_s2  <= fit_s1;
			yraw_s2 <= YRAW_W'(acc >>> WEIGHT_BITS);
			ent_s3  <= ent_c;
		end
	end

endmodule

/* hw/rtl/lpgf_queue.sv */
// Short register FIFO between front and back ends.
module lpgf_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lpgf_pkg::qent_t  push_ent,
	input  logic             pop,
	output lpgf_pkg::qent_t  pop_ent,
	output lpgf_pkg::qstat_t qstat
);
	import lpgf_pkg::*;

	qent_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q, rd_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               do_push, do_pop;

	assign qstat.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign pop_ent     = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_ent;
		end
	end

endmodule

/* hw/rtl/lpgf_back.sv */
// Back end: pipelined shrink-factor division, rebuild and output register.
module lpgf_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [lpgf_pkg::OUT_W-1:0] peak_level,
	input  lpgf_pkg::qstat_t           qstat,
	input  lpgf_pkg::qent_t            pop_ent,
	output logic                       pop,
	output logic                       res_valid,
	input  logic                       res_ready,
	output logic [lpgf_pkg::OUT_W-1:0] red_out,
	output logic [lpgf_pkg::OUT_W-1:0] green_out,
	output logic [lpgf_pkg::OUT_W-1:0] blue_out,
	output logic                       was_fitted
);
	import lpgf_pkg::*;

	localparam int LAM_STG = DIV_STEPS + 1;
	localparam int MUL_STG = DIV_STEPS + 2;

	logic                 en;
	logic                 v_q [B_STAGES];
	bstg_t                p_q [B_STAGES-1];
	bstg_t                nxt_c [B_STAGES-1];
	bstg_t                init_c;
	logic [2:0][OUT_W-1:0] res_q;
	logic                 fit_q;
	logic [2:0][OUT_W-1:0] res_c;
	logic [LAM_W-1:0]     m01;

	assign en  = !v_q[B_STAGES-1] || res_ready;
	assign pop = en && !qstat.empty;

	always_comb begin
		init_c = '0;
		init_c.fit = pop_ent.fit;
		init_c.x   = pop_ent.x;
		init_c.y   = pop_ent.y;
		init_c.c   = pop_ent.c;
		init_c.d   = pop_ent.d;
		for (int i = 0; i < 3; i++) begin
			logic sat;
			sat = !pop_ent.act[i] ||
				({{(CMP_W-NUM_W){1'b0}}, pop_ent.bound[i], {WEIGHT_BITS{1'b0}}}
				>= {pop_ent.d[i], {WEIGHT_BITS{1'b0}}});
			init_c.rem[i]  = {pop_ent.bound[i], {WEIGHT_BITS{1'b0}}};
			init_c.done[i] = sat;
			init_c.q[i]    = sat ? LAM_W'(LAM_ONE) : '0;
		end
		m01 = (p_q[LAM_STG-1].q[0] < p_q[LAM_STG-1].q[1]) ?
			p_q[LAM_STG-1].q[0] : p_q[LAM_STG-1].q[1];
		for (int i = 0; i < 3; i++) begin
			logic signed [RND_W-1:0] r;
			logic signed [SUM_W-1:0] s;
			r = RND_W'(($signed(p_q[B_STAGES-2].prod[i])
				+ MUL_W'(1 << (WEIGHT_BITS - 1))) >>> WEIGHT_BITS);
			s = $signed({{(SUM_W-OUT_W){1'b0}}, p_q[B_STAGES-2].y}) + SUM_W'(r);
			if (s < 0) begin
				res_c[i] = '0;
			end else if (s > $signed({{(SUM_W-OUT_W){1'b0}}, peak_level})) begin
				res_c[i] = peak_level;
			end else begin
				res_c[i] = s[OUT_W-1:0];
			end
			if (!p_q[B_STAGES-2].fit) begin
				res_c[i] = p_q[B_STAGES-2].x[i][OUT_W-1:0];
			end
		end
	end

	always_comb begin
		nxt_c[0] = init_c;
		for (int j = 1; j <= DIV_STEPS; j++) begin
			nxt_c[j] = p_q[j-1];
			for (int i = 0; i < 3; i++) begin
				logic [CMP_W-1:0] dk;
				dk = CMP_W'(p_q[j-1].d[i]) << (DIV_STEPS - j);
				if (!p_q[j-1].done[i] && (CMP_W'(p_q[j-1].rem[i]) >= dk)) begin
					nxt_c[j].rem[i] = NUM_W'(CMP_W'(p_q[j-1].rem[i]) - dk);
					nxt_c[j].q[i]   = p_q[j-1].q[i] | (LAM_W'(1) << (DIV_STEPS - j));
				end
			end
		end
		nxt_c[LAM_STG] = p_q[LAM_STG-1];
		nxt_c[LAM_STG].lam = (m01 < p_q[LAM_STG-1].q[2]) ? m01 : p_q[LAM_STG-1].q[2];
		nxt_c[MUL_STG] = p_q[MUL_STG-1];
		for (int i = 0; i < 3; i++) begin
			nxt_c[MUL_STG].prod[i] = $signed({1'b0, p_q[MUL_STG-1].lam})
				* $signed(p_q[MUL_STG-1].c[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < B_STAGES; j++) begin
				v_q[j] <= 1'b0;
			end
		end else if (en) begin
			v_q[0] <= !qstat.empty;
			for (int j = 1; j < B_STAGES; j++) begin
				v_q[j] <= v_q[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < B_STAGES - 1; j++) begin
				p_q[j] <= nxt_c[j];
			end
			res_q <= res_c;
			fit_q <= p_q[B_STAGES-2].fit;
		end
	end

	assign res_valid  = v_q[B_STAGES-1];
	assign red_out    = res_q[0];
	assign green_out  = res_q[1];
	assign blue_out   = res_q[2];
	assign was_fitted = fit_q;

endmodule

/* hw/rtl/luma_preserving_gamut_fit.sv */
// Top level of the luma preserving gamut fit block.
// Pixel channel: pix_valid/pix_ready with red_in, green_in, blue_in (signed Q16.16).
// Result channel: res_valid/res_ready with red_out, green_out, blue_out (Q15.16 in
// [0, peak_level]) and was_fitted. One word out for every word in, in order.
// Configuration: APB-style port, peak_level at 0x0, weight_red 0x4, weight_green 0x8,
// weight_blue 0xC; pready always high. Write only while the block is idle.
// Throughput: one pixel per clock while res_ready is high.
// Path from acceptance to res_valid with an empty queue: three front stages
// (products, luma sum, offsets), one queue slot, a 16-step pipelined divider for
// the shrink factor, minimum, multiply and the output register.
// Reset: pipelines and queue empty, registers at their documented defaults.
// Receiver stall: the back pipeline holds; the four-entry queue absorbs the
// front end's words, then pix_ready drops until the receiver takes a word.
module luma_preserving_gamut_fit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lpgf_pkg::ADDR_W-1:0]       paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              pix_valid,
	output logic                              pix_ready,
	input  logic signed [lpgf_pkg::CH_W-1:0]  red_in,
	input  logic signed [lpgf_pkg::CH_W-1:0]  green_in,
	input  logic signed [lpgf_pkg::CH_W-1:0]  blue_in,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic [lpgf_pkg::OUT_W-1:0]        red_out,
	output logic [lpgf_pkg::OUT_W-1:0]        green_out,
	output logic [lpgf_pkg::OUT_W-1:0]        blue_out,
	output logic                              was_fitted
);
	import lpgf_pkg::*;

	logic [OUT_W-1:0] peak_q;
	logic [15:0]      wr_q, wg_q, wb_q;
	logic             wen;
	reg_idx_t         idx;
	logic             push, pop;
	qent_t            push_ent, pop_ent;
	qstat_t           qstat;

	assign pready = 1'b1;
	assign wen    = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= OUT_W'(65536);
			wr_q   <= 16'd17216;
			wg_q   <= 16'd44433;
			wb_q   <= 16'd3886;
		end else if (wen) begin
			case (idx)
				REG_PEAK:  peak_q <= pwdata[OUT_W-1:0];
				REG_W_RED: wr_q   <= pwdata[15:0];
				REG_W_GRN: wg_q   <= pwdata[15:0];
				REG_W_BLU: wb_q   <= pwdata[15:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PEAK:  prdata = {1'b0, peak_q};
			REG_W_RED: prdata = {16'b0, wr_q};
			REG_W_GRN: prdata = {16'b0, wg_q};
			REG_W_BLU: prdata = {16'b0, wb_q};
			default:   prdata = '0;
		endcase
	end

	lpgf_front u_front (
		.clk, .arst_n,
		.peak_level(peak_q), .weight_red(wr_q), .weight_green(wg_q), .weight_blue(wb_q),
		.pix_valid, .pix_ready, .red_in, .green_in, .blue_in,
		.qstat, .push, .push_ent
	);

	lpgf_queue u_queue (
		.clk, .arst_n, .push, .push_ent, .pop, .pop_ent, .qstat
	);

	lpgf_back u_back (
		.clk, .arst_n, .peak_level(peak_q), .qstat, .pop_ent, .pop,
		.res_valid, .res_ready, .red_out, .green_out, .blue_out, .was_fitted
	);

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && was_fitted |-> red_out <= peak_q && green_out <= peak_q
			&& blue_out <= peak_q)
		else $error("fitted word outside range");

	a_queue: assert property (@(posedge clk) disable iff (!arst_n)
		!(qstat.full && qstat.empty))
		else $error("queue status inconsistent");

	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

endmodule
